[design/ffca_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and fixed constants of the first-fit coalescing allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    // Fixed field widths of the request and response items.
    localparam int REQ_W   = 32;
    localparam int ALIGN_W = 17;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_ALLOC    = 2'd0,
        REQ_RESIDENT = 2'd1,
        REQ_FREE     = 2'd2,
        REQ_CLEAR    = 2'd3
    } req_type_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_SPACE   = 2'd1,
        ST_BAD_OFFSET = 2'd2,
        ST_OVERLAP    = 2'd3
    } status_t;

    // Configuration register indexes.
    localparam logic REG_ALIGNMENT    = 1'b0;
    localparam logic REG_ALIGN_ENABLE = 1'b1;

    // Register reset values.
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 17'd256;

endpackage : ffca_pkg
`default_nettype wire

[design/ffca_channels.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_channels
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------

// Request channel: one item per allocate, resident allocate, free or clear.
interface ffca_req_if;
    import ffca_pkg::*;
    logic             valid;
    logic             ready;
    logic [1:0]       req_type;
    logic [REQ_W-1:0] req_size;
    logic [REQ_W-1:0] req_offset;

    modport source (output valid, req_type, req_size, req_offset, input ready);
    modport sink   (input valid, req_type, req_size, req_offset, output ready);
endinterface : ffca_req_if

// Response channel: one item per request.
interface ffca_rsp_if;
    import ffca_pkg::*;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] granted_offset;
    logic [1:0]       status;

    modport source (output valid, granted_offset, status, input ready);
    modport sink   (input valid, granted_offset, status, output ready);
endinterface : ffca_rsp_if
`default_nettype wire

[design/first_fit_coalescing_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit
// First-fit offset allocator with a sorted free table that merges neighbors.
//
//   Channel  Dir  Handshake            Payload
//   req      in   valid/ready          req_type, req_size, req_offset
//   rsp      out  valid/ready          granted_offset, status
//   apb      in   psel/penable/pready  paddr, pwdata, prdata
//
// Items are handled one at a time; the time a request takes is set by the
// walks over the used table and the free table, one RAM entry per cycle.
// Reset clears the control state and the used valid bits at once; no sweep.
// A new item is taken while the previous response waits on the rsp side.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_unit #(
    parameter int FREE_ENTRIES = 64,
    parameter int USED_ENTRIES = 64,
    parameter int ADDR_BITS    = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffca_req_if.sink         req,
    ffca_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ffca_pkg::*;

    localparam int FI   = $clog2(FREE_ENTRIES);
    localparam int UI   = $clog2(USED_ENTRIES);
    localparam int PW   = ((FI > UI) ? FI : UI) + 1;
    localparam int CNTW = FI + 1;
    localparam int CW   = ((ADDR_BITS > 33) ? ADDR_BITS : 33) + 2;
    localparam int SZW  = ADDR_BITS + 1;
    localparam int EW   = ADDR_BITS + SZW;
    localparam logic [CW-1:0] ARENA_LIMIT = CW'(1) << ADDR_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOT, S_FSCAN, S_BUMP, S_SHDN,
        S_UFIND, S_PSCAN, S_SHUP, S_INS, S_RESP
    } state_t;

    state_t                  state_reg, state_next;
    logic [PW-1:0]           ptr_reg, ptr_next;
    logic [PW-1:0]           p_reg, p_next;
    logic [1:0]              type_reg, type_next;
    logic [REQ_W-1:0]        off_reg, off_next;
    logic [CW-1:0]           sz_reg, sz_next;
    logic [CW-1:0]           szg_reg, szg_next;
    logic [UI-1:0]           slot_reg, slot_next;
    logic [SZW-1:0]          bsize_reg, bsize_next;
    logic [CW-1:0]           bend_reg, bend_next;
    logic [ADDR_BITS-1:0]    aoff_reg, aoff_next;
    logic [SZW-1:0]          rec_reg, rec_next;
    logic [ADDR_BITS-1:0]    prev_off_reg, prev_off_next;
    logic [SZW-1:0]          prev_size_reg, prev_size_next;
    logic [CW-1:0]           prev_end_reg, prev_end_next;
    logic [CNTW-1:0]         count_reg, count_next;
    logic [SZW-1:0]          bump_reg, bump_next;
    logic [USED_ENTRIES-1:0] valid_reg, valid_next;
    logic [USED_ENTRIES-1:0] resident_reg, resident_next;
    logic [REQ_W-1:0]        res_granted_reg, res_granted_next;
    logic [1:0]              res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [REQ_W-1:0]        out_granted_reg, out_granted_next;
    logic [1:0]              out_status_reg, out_status_next;
    logic [ALIGN_W-1:0]      align_reg;
    logic                    align_en_reg;

    // RAM ports.
    logic          fwe, uwe;
    logic [FI-1:0] fwaddr;
    logic [EW-1:0] fwdata, frd;
    logic [UI-1:0] uwaddr;
    logic [EW-1:0] uwdata, urd;

    // Fields of the entries read from the RAMs.
    logic [CW-1:0] f_off_x, f_size_x, u_off_x, off_x;
    logic [CW-1:0] gran, sz0, sz_round, sum3, bump_sum;
    logic [PW-1:0] ptr_m1, count_x;
    logic          req_fire, cfg_wr;
    logic          alloc_done;
    logic [ADDR_BITS-1:0] alloc_off;
    logic [SZW-1:0]       alloc_rec;
    logic [CW-1:0]        alloc_off_x, split_off;

    assign f_off_x  = CW'(frd[EW-1:SZW]);
    assign f_size_x = CW'(frd[SZW-1:0]);
    assign u_off_x  = CW'(urd[EW-1:SZW]);
    assign off_x    = CW'(off_reg);
    assign ptr_m1   = ptr_reg - PW'(1);
    assign count_x  = PW'(count_reg);
    assign sum3     = CW'(prev_size_reg) + CW'(bsize_reg) + f_size_x;
    assign bump_sum = CW'(bump_reg) + sz_reg;
    assign split_off = f_off_x + sz_reg;

    // Free table: offsets and sizes, sorted by offset.
    ffca_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_free_ram (
        .clk   (clk),
        .we    (fwe),
        .waddr (fwaddr),
        .wdata (fwdata),
        .raddr (ptr_next[FI-1:0]),
        .rdata (frd)
    );

    // Used table: offsets and recorded sizes.
    ffca_ram #(.WIDTH(EW), .DEPTH(USED_ENTRIES)) u_used_ram (
        .clk   (clk),
        .we    (uwe),
        .waddr (uwaddr),
        .wdata (uwdata),
        .raddr (ptr_next[UI-1:0]),
        .rdata (urd)
    );

    // Granule: highest power of two not above the alignment register, or one if it is zero.
    always_comb
    begin
        gran = CW'(1);
        for (int b = 0; b < ALIGN_W; b++)
        begin
            if (align_reg[b])
            begin
                gran = CW'(1) << b;
            end
        end
    end

    // Size rounding for a new request.
    assign sz0      = (req.req_size == '0) ? CW'(1) : CW'(req.req_size);
    assign sz_round = (sz0 + gran - CW'(1)) & ~(gran - CW'(1));

    // Handshakes.
    assign req.ready          = (state_reg == S_IDLE);
    assign req_fire           = req.valid && req.ready;
    assign rsp.valid          = out_valid_reg;
    assign rsp.granted_offset = out_granted_reg;
    assign rsp.status         = out_status_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ALIGN_ENABLE) ? {31'd0, align_en_reg}
                                                   : {15'd0, align_reg};

    // Sequencer next-state logic.
    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        p_next           = p_reg;
        type_next        = type_reg;
        off_next         = off_reg;
        sz_next          = sz_reg;
        szg_next         = szg_reg;
        slot_next        = slot_reg;
        bsize_next       = bsize_reg;
        bend_next        = bend_reg;
        aoff_next        = aoff_reg;
        rec_next         = rec_reg;
        prev_off_next    = prev_off_reg;
        prev_size_next   = prev_size_reg;
        prev_end_next    = prev_end_reg;
        count_next       = count_reg;
        bump_next        = bump_reg;
        valid_next       = valid_reg;
        resident_next    = resident_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        fwe              = 1'b0;
        fwaddr           = ptr_reg[FI-1:0];
        fwdata           = frd;
        uwe              = 1'b0;
        uwaddr           = slot_reg;
        uwdata           = '0;
        alloc_done       = 1'b0;
        alloc_off        = aoff_reg;
        alloc_rec        = rec_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    type_next = req.req_type;
                    off_next  = req.req_offset;
                    sz_next   = align_en_reg ? sz_round : sz0;
                    ptr_next  = '0;
                    case (req.req_type)
                        REQ_CLEAR:
                        begin
                            bump_next        = '0;
                            count_next       = '0;
                            valid_next       = '0;
                            resident_next    = '0;
                            res_granted_next = '0;
                            res_status_next  = ST_OK;
                            state_next       = S_RESP;
                        end
                        REQ_FREE:
                        begin
                            state_next = S_UFIND;
                        end
                        default:
                        begin
                            state_next = S_SLOT;
                        end
                    endcase
                end
            end

            // Look for an unused entry in the used table.
            S_SLOT:
            begin
                szg_next = sz_reg + gran;
                if (!valid_reg[ptr_reg[UI-1:0]])
                begin
                    slot_next  = ptr_reg[UI-1:0];
                    ptr_next   = '0;
                    state_next = (type_reg == REQ_RESIDENT) ? S_BUMP : S_FSCAN;
                end
                else if (ptr_reg == PW'(USED_ENTRIES - 1))
                begin
                    res_granted_next = '0;
                    res_status_next  = ST_NO_SPACE;
                    state_next       = S_RESP;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            // First-fit walk over the free table.
            S_FSCAN:
            begin
                if (ptr_reg >= count_x)
                begin
                    state_next = S_BUMP;
                end
                else if (f_size_x >= sz_reg)
                begin
                    if (f_size_x >= szg_reg)
                    begin
                        fwe        = 1'b1;
                        fwaddr     = ptr_reg[FI-1:0];
                        fwdata     = {split_off[ADDR_BITS-1:0],
                                      SZW'(f_size_x - sz_reg)};
                        alloc_done = 1'b1;
                        alloc_off  = frd[EW-1:SZW];
                        alloc_rec  = SZW'(sz_reg);
                    end
                    else
                    begin
                        aoff_next  = frd[EW-1:SZW];
                        rec_next   = frd[SZW-1:0];
                        ptr_next   = ptr_reg + PW'(1);
                        state_next = S_SHDN;
                    end
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            // Take space from the bump pointer.
            S_BUMP:
            begin
                if (bump_sum > ARENA_LIMIT)
                begin
                    res_granted_next = '0;
                    res_status_next  = ST_NO_SPACE;
                    state_next       = S_RESP;
                end
                else
                begin
                    bump_next  = bump_sum[SZW-1:0];
                    alloc_done = 1'b1;
                    alloc_off  = bump_reg[ADDR_BITS-1:0];
                    alloc_rec  = SZW'(sz_reg);
                end
            end

            // Close the gap left by a removed free entry.
            S_SHDN:
            begin
                if (ptr_reg < count_x)
                begin
                    fwe      = 1'b1;
                    fwaddr   = ptr_m1[FI-1:0];
                    fwdata   = frd;
                    ptr_next = ptr_reg + PW'(1);
                end
                else
                begin
                    count_next = count_reg - CNTW'(1);
                    if (type_reg == REQ_FREE)
                    begin
                        valid_next[slot_reg] = 1'b0;
                        res_granted_next     = '0;
                        res_status_next      = ST_OK;
                        state_next           = S_RESP;
                    end
                    else
                    begin
                        alloc_done = 1'b1;
                    end
                end
            end

            // Find the used entry that holds the offset being freed.
            S_UFIND:
            begin
                if (valid_reg[ptr_reg[UI-1:0]] && (u_off_x == off_x))
                begin
                    if (resident_reg[ptr_reg[UI-1:0]])
                    begin
                        res_granted_next = '0;
                        res_status_next  = ST_BAD_OFFSET;
                        state_next       = S_RESP;
                    end
                    else
                    begin
                        slot_next  = ptr_reg[UI-1:0];
                        bsize_next = urd[SZW-1:0];
                        bend_next  = off_x + CW'(urd[SZW-1:0]);
                        ptr_next   = '0;
                        state_next = S_PSCAN;
                    end
                end
                else if (ptr_reg == PW'(USED_ENTRIES - 1))
                begin
                    res_granted_next = '0;
                    res_status_next  = ST_BAD_OFFSET;
                    state_next       = S_RESP;
                end
                else
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
            end

            // Find the insert position and merge with the neighbors.
            S_PSCAN:
            begin
                if ((ptr_reg < count_x) && (f_off_x < off_x))
                begin
                    prev_off_next  = frd[EW-1:SZW];
                    prev_size_next = frd[SZW-1:0];
                    prev_end_next  = f_off_x + f_size_x;
                    ptr_next       = ptr_reg + PW'(1);
                end
                else
                begin
                    p_next = ptr_reg;
                    res_granted_next = '0;
                    res_status_next  = ST_OK;
                    if (((ptr_reg != '0) && (prev_end_reg > off_x)) ||
                        ((ptr_reg < count_x) && (bend_reg > f_off_x)))
                    begin
                        res_status_next = ST_OVERLAP;
                        state_next      = S_RESP;
                    end
                    else if ((ptr_reg != '0) && (prev_end_reg == off_x) &&
                             (ptr_reg < count_x) && (bend_reg == f_off_x))
                    begin
                        // Joins both neighbors: grow the previous one, drop the next.
                        fwe        = 1'b1;
                        fwaddr     = ptr_m1[FI-1:0];
                        fwdata     = {prev_off_reg, sum3[SZW-1:0]};
                        ptr_next   = ptr_reg + PW'(1);
                        state_next = S_SHDN;
                    end
                    else if ((ptr_reg != '0) && (prev_end_reg == off_x))
                    begin
                        fwe    = 1'b1;
                        fwaddr = ptr_m1[FI-1:0];
                        fwdata = {prev_off_reg, SZW'(CW'(prev_size_reg) + CW'(bsize_reg))};
                        valid_next[slot_reg] = 1'b0;
                        state_next = S_RESP;
                    end
                    else if ((ptr_reg < count_x) && (bend_reg == f_off_x))
                    begin
                        fwe    = 1'b1;
                        fwaddr = ptr_reg[FI-1:0];
                        fwdata = {off_x[ADDR_BITS-1:0], SZW'(f_size_x + CW'(bsize_reg))};
                        valid_next[slot_reg] = 1'b0;
                        state_next = S_RESP;
                    end
                    else if (count_reg == CNTW'(FREE_ENTRIES))
                    begin
                        res_status_next = ST_NO_SPACE;
                        state_next      = S_RESP;
                    end
                    else if (ptr_reg == count_x)
                    begin
                        state_next = S_INS;
                    end
                    else
                    begin
                        ptr_next   = count_x - PW'(1);
                        state_next = S_SHUP;
                    end
                end
            end

            // Open a gap at the insert position, from the top down.
            S_SHUP:
            begin
                fwe    = 1'b1;
                fwaddr = FI'(ptr_reg + PW'(1));
                fwdata = frd;
                if (ptr_reg == p_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    ptr_next = ptr_m1;
                end
            end

            // Write the freed block as a new entry.
            S_INS:
            begin
                fwe                  = 1'b1;
                fwaddr               = p_reg[FI-1:0];
                fwdata               = {off_x[ADDR_BITS-1:0], bsize_reg};
                count_next           = count_reg + CNTW'(1);
                valid_next[slot_reg] = 1'b0;
                res_granted_next     = '0;
                res_status_next      = ST_OK;
                state_next           = S_RESP;
            end

            // Hand the result to the output register once it is free.
            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Record a successful allocation in the used table.
        if (alloc_done)
        begin
            uwe                     = 1'b1;
            uwaddr                  = slot_reg;
            uwdata                  = {alloc_off, alloc_rec};
            valid_next[slot_reg]    = 1'b1;
            resident_next[slot_reg] = (type_reg == REQ_RESIDENT);
            res_granted_next        = alloc_off_x[REQ_W-1:0];
            res_status_next         = ST_OK;
            state_next              = S_RESP;
        end
    end

    assign alloc_off_x = CW'(alloc_off);

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            bump_reg      <= '0;
            valid_reg     <= '0;
            resident_reg  <= '0;
            out_valid_reg <= 1'b0;
            align_reg     <= ALIGN_RESET;
            align_en_reg  <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            valid_reg     <= valid_next;
            resident_reg  <= resident_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && (paddr[2] == REG_ALIGNMENT))
            begin
                align_reg <= pwdata[ALIGN_W-1:0];
            end
            if (cfg_wr && (paddr[2] == REG_ALIGN_ENABLE))
            begin
                align_en_reg <= pwdata[0];
            end
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        ptr_reg         <= ptr_next;
        p_reg           <= p_next;
        type_reg        <= type_next;
        off_reg         <= off_next;
        sz_reg          <= sz_next;
        szg_reg         <= szg_next;
        slot_reg        <= slot_next;
        bsize_reg       <= bsize_next;
        bend_reg        <= bend_next;
        aoff_reg        <= aoff_next;
        rec_reg         <= rec_next;
        prev_off_reg    <= prev_off_next;
        prev_size_reg   <= prev_size_next;
        prev_end_reg    <= prev_end_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
    end

    // The free table never holds more blocks than it has entries.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(FREE_ENTRIES))
        else $error("free count beyond table depth");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("accepted item not started");

    // The free table is written only while an item is at work.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fwe |-> (state_reg != S_IDLE) && (state_reg != S_RESP))
        else $error("free table written while idle");

    // The free count moves by at most one per cycle, except on clear.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNTW'(1)) ||
             (count_reg == $past(count_reg) - CNTW'(1)) ||
             (count_reg == '0)))
        else $error("free count jumped");

endmodule : first_fit_coalescing_allocator_unit
`default_nettype wire

[design/ffca_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffca_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : ffca_ram
`default_nettype wire

[sim/first_fit_coalescing_allocator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_coalescing_allocator_unit_tb
// Drives allocate, free and clear requests into the allocator, tracks the
// arena in a behavioral copy of its tables and compares every response with
// the predicted offset and status, under changing alignment and idle patterns.
// ----------------------------------------------------------------------------
module first_fit_coalescing_allocator_unit_tb;
    import ffca_pkg::*;

    localparam int FREE_N = 64;
    localparam int USED_N = 64;
    localparam logic [63:0] ARENA_END = 64'd1 << 32;
    localparam logic [2:0] ADDR_ALIGNMENT = 3'd0;
    localparam logic [2:0] ADDR_ALIGN_ENABLE = 3'd4;
    localparam int DRAIN_CYCLES = 250;

    // Idle patterns.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SENDER = 1;
    localparam int IDLE_RECEIVER = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic [31:0] offset;
        status_t     status;
    } grant_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    ffca_req_if req_ch ();
    ffca_rsp_if rsp_ch ();

    first_fit_coalescing_allocator_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the allocator registers and tables.
    logic [16:0] align_q;
    logic        align_en_q;
    logic [63:0] bump_q;
    logic [63:0] hole_ofs [FREE_N];
    logic [63:0] hole_len [FREE_N];
    int          hole_cnt;
    logic [63:0] lease_ofs [USED_N];
    logic [63:0] lease_len [USED_N];
    bit          lease_live [USED_N];
    bit          lease_pinned [USED_N];

    grant_t pending_grants[$];
    int     errors;
    int     idle_mode;

    // Values seen at the falling edge, stable across the next rising edge.
    logic        s_req_ready;
    logic        s_rsp_valid;
    logic        s_rsp_ready;
    logic [31:0] s_rsp_offset;
    logic [1:0]  s_rsp_status;

    // Clock.
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Run limit.
    initial
    begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        s_req_ready  <= req_ch.ready;
        s_rsp_valid  <= rsp_ch.valid;
        s_rsp_ready  <= rsp_ch.ready;
        s_rsp_offset <= rsp_ch.granted_offset;
        s_rsp_status <= rsp_ch.status;
    end

    // Response back-pressure.
    always @(posedge clk)
    begin
        if (idle_mode == IDLE_RECEIVER)
            rsp_ch.ready <= ($urandom_range(0, 99) >= 62);
        else if (idle_mode == IDLE_BOTH)
            rsp_ch.ready <= ($urandom_range(0, 99) >= 22);
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && s_rsp_valid && s_rsp_ready)
        begin
            if (pending_grants.size() == 0)
                report_mismatch("unexpected response", 32'd0, s_rsp_offset);
            else
            begin
                g = pending_grants.pop_front();
                if (s_rsp_offset !== g.offset)
                    report_mismatch("granted_offset", g.offset, s_rsp_offset);
                if (s_rsp_status !== g.status)
                    report_mismatch("status", 32'(g.status), 32'(s_rsp_status));
            end
        end
    end

    function automatic logic [63:0] granule_of(logic [16:0] a);
        logic [63:0] p;
        p = 64'd1;
        for (int b = 16; b >= 0; b--)
            if (a[b])
            begin
                p = 64'd1 << b;
                break;
            end
        return p;
    endfunction

    function automatic void clear_arena();
        bump_q = 64'd0;
        hole_cnt = 0;
        for (int k = 0; k < USED_N; k++)
        begin
            lease_live[k] = 1'b0;
            lease_pinned[k] = 1'b0;
        end
    endfunction

    function automatic void drop_hole(int i);
        for (int k = i; k < hole_cnt - 1; k++)
        begin
            hole_ofs[k] = hole_ofs[k + 1];
            hole_len[k] = hole_len[k + 1];
        end
        hole_cnt--;
    endfunction

    function automatic grant_t place_block(logic [31:0] size, bit pinned);
        grant_t r;
        logic [63:0] g, sz, off, rec;
        int slot, i;
        r.offset = 32'd0;
        r.status = ST_NO_SPACE;
        g = granule_of(align_q);
        sz = (size == 0) ? 64'd1 : 64'(size);
        if (align_en_q)
            sz = (sz + g - 1) & ~(g - 1);
        slot = -1;
        for (int k = 0; k < USED_N; k++)
            if (!lease_live[k])
            begin
                slot = k;
                break;
            end
        if (slot < 0)
            return r;
        // First fit among the holes; resident requests always bump.
        i = hole_cnt;
        if (!pinned)
            for (i = 0; i < hole_cnt; i++)
                if (hole_len[i] >= sz)
                    break;
        if (i < hole_cnt)
        begin
            off = hole_ofs[i];
            if (hole_len[i] >= sz + g)
            begin
                hole_ofs[i] += sz;
                hole_len[i] -= sz;
                rec = sz;
            end
            else
            begin
                rec = hole_len[i];
                drop_hole(i);
            end
        end
        else
        begin
            if (bump_q + sz > ARENA_END)
                return r;
            off = bump_q;
            bump_q += sz;
            rec = sz;
        end
        lease_ofs[slot] = off;
        lease_len[slot] = rec;
        lease_live[slot] = 1'b1;
        lease_pinned[slot] = pinned;
        r.offset = off[31:0];
        r.status = ST_OK;
        return r;
    endfunction

    function automatic status_t release_block(logic [31:0] ofs);
        logic [63:0] off, len, blk_end;
        int u, p;
        bit join_lo, join_hi;
        off = 64'(ofs);
        u = -1;
        for (int k = 0; k < USED_N; k++)
            if (lease_live[k] && lease_ofs[k] == off)
            begin
                u = k;
                break;
            end
        if (u < 0 || lease_pinned[u])
            return ST_BAD_OFFSET;
        len = lease_len[u];
        blk_end = off + len;
        for (p = 0; p < hole_cnt; p++)
            if (hole_ofs[p] >= off)
                break;
        if (p > 0 && hole_ofs[p - 1] + hole_len[p - 1] > off)
            return ST_OVERLAP;
        if (p < hole_cnt && blk_end > hole_ofs[p])
            return ST_OVERLAP;
        join_lo = p > 0 && hole_ofs[p - 1] + hole_len[p - 1] == off;
        join_hi = p < hole_cnt && blk_end == hole_ofs[p];
        if (join_lo && join_hi)
        begin
            hole_len[p - 1] += len + hole_len[p];
            drop_hole(p);
        end
        else if (join_lo)
            hole_len[p - 1] += len;
        else if (join_hi)
        begin
            hole_ofs[p] = off;
            hole_len[p] += len;
        end
        else
        begin
            if (hole_cnt >= FREE_N)
                return ST_NO_SPACE;
            for (int k = hole_cnt; k > p; k--)
            begin
                hole_ofs[k] = hole_ofs[k - 1];
                hole_len[k] = hole_len[k - 1];
            end
            hole_ofs[p] = off;
            hole_len[p] = len;
            hole_cnt++;
        end
        lease_live[u] = 1'b0;
        return ST_OK;
    endfunction

    function automatic grant_t predict_grant(req_type_t kind, logic [31:0] size,
                                             logic [31:0] ofs);
        grant_t r;
        r.offset = 32'd0;
        r.status = ST_OK;
        case (kind)
            REQ_ALLOC: r = place_block(size, 1'b0);
            REQ_RESIDENT: r = place_block(size, 1'b1);
            REQ_FREE: r.status = release_block(ofs);
            default: clear_arena();
        endcase
        return r;
    endfunction

    // Send one request item; called in the time step of a rising edge.
    task automatic send_request(req_type_t kind, logic [31:0] size, logic [31:0] ofs);
        int gap_pct;
        grant_t want;
        gap_pct = (idle_mode == IDLE_SENDER) ? 62 : (idle_mode == IDLE_BOTH) ? 22 : 0;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.req_size <= size;
        req_ch.req_offset <= ofs;
        @(posedge clk);
        while (!s_req_ready)
            @(posedge clk);
        want = predict_grant(kind, size, ofs);
        pending_grants.insert(pending_grants.size(), want);
    endtask

    // Lower valid, wait for all responses, then let a full request time pass.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_ALIGNMENT)
            align_q = data[16:0];
        else
            align_en_q = data[0];
    endtask

    task automatic configure(logic [16:0] align, logic enable);
        wait_idle();
        write_register(ADDR_ALIGNMENT, 32'(align));
        write_register(ADDR_ALIGN_ENABLE, 32'(enable));
    endtask

    // Offset of a random live block, or any offset when none is live.
    function automatic logic [31:0] pick_lease();
        int start;
        start = $urandom_range(0, USED_N - 1);
        for (int k = 0; k < USED_N; k++)
            if (lease_live[(start + k) % USED_N])
                return lease_ofs[(start + k) % USED_N][31:0];
        return $urandom;
    endfunction

    // Sizes: mostly small, some in any range, a few at the extremes.
    function automatic logic [31:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2048);
        else if (r < 85)
            return $urandom_range(0, 300000);
        else if (r < 90)
            return 32'd0;
        else if (r < 96)
            return $urandom;
        else
            return 32'hFFFF_FFFF - $urandom_range(0, 255);
    endfunction

    // Reset values, size edge cases, full arena and out-of-range frees.
    task automatic test_defaults_and_extremes();
        send_request(REQ_ALLOC, 32'd0, 32'd0);
        send_request(REQ_ALLOC, 32'd1, 32'hFFFF_FFFF);
        send_request(REQ_RESIDENT, 32'd257, 32'd0);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_request(REQ_FREE, 32'hFFFF_FFFF, 32'd512);
        send_request(REQ_FREE, 32'd0, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'hFFFF_FF00, 32'd0);
        send_request(REQ_ALLOC, 32'd256, 32'd0);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
    endtask

    // Free, split, whole-block take and merging with both neighbors.
    task automatic test_reuse_and_merge();
        send_request(REQ_ALLOC, 32'd100, 32'd0);
        send_request(REQ_ALLOC, 32'd600, 32'd0);
        send_request(REQ_ALLOC, 32'd300, 32'd0);
        send_request(REQ_ALLOC, 32'd10, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd256);
        send_request(REQ_FREE, 32'd0, 32'd256);
        send_request(REQ_ALLOC, 32'd200, 32'd0);
        send_request(REQ_ALLOC, 32'd300, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd512);
        send_request(REQ_FREE, 32'd0, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd1024);
        send_request(REQ_FREE, 32'd0, 32'd256);
        send_request(REQ_ALLOC, 32'd1500, 32'd0);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
    endtask

    // Fill the lease table, then one more request must fail.
    task automatic test_lease_table_full();
        for (int k = 0; k <= USED_N; k++)
            send_request((k % 2) ? REQ_RESIDENT : REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_FREE, 32'd0, 32'd256);
        send_request(REQ_ALLOC, 32'd1, 32'd0);
        send_request(REQ_CLEAR, 32'd0, 32'd0);
    endtask

    // Mostly allocate and free of live blocks, with noise and clears.
    task automatic test_random_traffic(int count);
        int r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 42)
                send_request(REQ_ALLOC, pick_size(), $urandom);
            else if (r < 52)
                send_request(REQ_RESIDENT, pick_size(), $urandom);
            else if (r < 88)
                send_request(REQ_FREE, $urandom, pick_lease());
            else if (r < 97)
                send_request(REQ_FREE, $urandom, $urandom);
            else
                send_request(REQ_CLEAR, $urandom, $urandom);
        end
    endtask

    initial
    begin
        errors = 0;
        idle_mode = IDLE_NONE;
        align_q = ALIGN_RESET;
        align_en_q = 1'b1;
        clear_arena();
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 3'd0;
        pwdata <= 32'd0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_ALLOC;
        req_ch.req_size <= 32'd0;
        req_ch.req_offset <= 32'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_and_extremes();
        test_reuse_and_merge();
        test_lease_table_full();
        configure(17'd1, 1'b1);
        test_reuse_and_merge();
        configure(17'd0, 1'b0);
        test_defaults_and_extremes();

        // Random phases over alignments and idle patterns.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: configure(17'd256, 1'b1);
                1: configure(17'd1, 1'b1);
                2: configure(17'h1FFFF, 1'b1);
                3: configure(17'd100, 1'b0);
                4: configure(17'd65536, 1'b1);
                5: configure(17'd0, 1'b1);
                6: configure(17'(1 << $urandom_range(0, 16)), 1'b1);
                default: configure(17'($urandom), 1'($urandom));
            endcase
            idle_mode = ph % 4;
            test_random_traffic(225);
        end
        idle_mode = IDLE_NONE;
        wait_idle();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : first_fit_coalescing_allocator_unit_tb
